### hdl/ehc_pkg.sv
// Shared types and constants for the Ethernet header classifier.
// Depends on nothing; every other file in hdl imports it.
`timescale 1ns / 1ps

package ehc_pkg;

	localparam int unsigned CNT_W = 14;

	localparam logic [CNT_W-1:0] COUNT_MAX    = 14'd16383;
	localparam logic [CNT_W-1:0] ETH_HDR_LEN  = 14'd14;
	localparam logic [CNT_W-1:0] IPV4_MIN_LEN = 14'd34;
	localparam logic [CNT_W-1:0] ARP_MIN_LEN  = 14'd42;

	localparam logic [15:0] TYPE_IPV4 = 16'h0800;
	localparam logic [15:0] TYPE_ARP  = 16'h0806;
	localparam logic [15:0] TYPE_IPV6 = 16'h86DD;

	localparam logic [15:0] PROTO_ICMP = 16'd1;
	localparam logic [15:0] PROTO_TCP  = 16'd6;
	localparam logic [15:0] PROTO_UDP  = 16'd17;

	localparam logic [3:0] IP_VERSION_4 = 4'd4;
	localparam logic [3:0] IHL_MIN      = 4'd5;

	localparam logic [2:0] KIND_RUNT      = 3'd0;
	localparam logic [2:0] KIND_OTHER     = 3'd1;
	localparam logic [2:0] KIND_ARP       = 3'd2;
	localparam logic [2:0] KIND_IPV6      = 3'd3;
	localparam logic [2:0] KIND_V4_TRUNC  = 3'd4;
	localparam logic [2:0] KIND_BAD_VER   = 3'd5;
	localparam logic [2:0] KIND_BAD_IHL   = 3'd6;
	localparam logic [2:0] KIND_IPV4      = 3'd7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic [13:0] frame_length;
		logic [2:0]  kind;
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [15:0] ethertype;
		logic [31:0] addr_first;
		logic [31:0] addr_second;
		logic [47:0] arp_hw_addr;
		logic [15:0] op_or_proto;
		logic        detail_valid;
		logic [15:0] port_first;
		logic [15:0] port_second;
	} out_beat_t;

	// Per-frame capture state
	typedef struct packed {
		logic [CNT_W-1:0] byte_count;
		logic [47:0]      dst_mac;
		logic [47:0]      src_mac;
		logic [15:0]      ethertype;
		logic [7:0]       version_ihl;
		logic [15:0]      op_proto;
		logic [31:0]      addr_first;
		logic [31:0]      addr_second;
		logic [47:0]      hw_addr;
		logic [15:0]      port_first;
		logic [15:0]      port_second;
	} frame_state_t;

	// L4 header offset from the IHL nibble: 14 + 4*IHL
	function automatic logic [CNT_W-1:0] l4_offset(input logic [3:0] ihl);
		return ETH_HDR_LEN + {{(CNT_W-6){1'b0}}, ihl, 2'b00};
	endfunction

endpackage

### hdl/ehc_capture.sv
// Byte position counter and header field capture for one frame.
// Depends on ehc_pkg; exposes the updated state of the current beat.
`timescale 1ns / 1ps

module ehc_capture (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  ehc_pkg::in_beat_t    beat,
	output ehc_pkg::frame_state_t nxt
);
	import ehc_pkg::*;

	frame_state_t st_q;
	logic [CNT_W-1:0] pos;
	logic [CNT_W-1:0] l4;
	logic [7:0] b;

	// Work out the state after this beat
	always_comb begin
		pos = st_q.byte_count;
		b   = beat.data_byte;
		nxt = st_q;

		if (pos < 14'd6) begin
			nxt.dst_mac = {st_q.dst_mac[39:0], b};
		end else if (pos < 14'd12) begin
			nxt.src_mac = {st_q.src_mac[39:0], b};
		end else if (pos < ETH_HDR_LEN) begin
			nxt.ethertype = {st_q.ethertype[7:0], b};
		end
		if (pos == ETH_HDR_LEN) begin
			nxt.version_ihl = b;
		end

		l4 = l4_offset(nxt.version_ihl[3:0]);

		if (nxt.ethertype == TYPE_ARP) begin
			if (pos == 14'd20 || pos == 14'd21) begin
				nxt.op_proto = {st_q.op_proto[7:0], b};
			end else if (pos >= 14'd22 && pos <= 14'd27) begin
				nxt.hw_addr = {st_q.hw_addr[39:0], b};
			end else if (pos >= 14'd28 && pos <= 14'd31) begin
				nxt.addr_first = {st_q.addr_first[23:0], b};
			end else if (pos >= 14'd38 && pos <= 14'd41) begin
				nxt.addr_second = {st_q.addr_second[23:0], b};
			end
		end else if (nxt.ethertype == TYPE_IPV4) begin
			if (pos == 14'd23) begin
				nxt.op_proto = {8'h00, b};
			end else if (pos >= 14'd26 && pos <= 14'd29) begin
				nxt.addr_first = {st_q.addr_first[23:0], b};
			end else if (pos >= 14'd30 && pos <= 14'd33) begin
				nxt.addr_second = {st_q.addr_second[23:0], b};
			end
			if (pos > ETH_HDR_LEN) begin
				if (pos == l4 || pos == l4 + 14'd1) begin
					nxt.port_first = {st_q.port_first[7:0], b};
				end else if (pos == l4 + 14'd2 || pos == l4 + 14'd3) begin
					nxt.port_second = {st_q.port_second[7:0], b};
				end
			end
		end

		// Saturate the length count
		if (st_q.byte_count != COUNT_MAX) begin
			nxt.byte_count = st_q.byte_count + 14'd1;
		end
	end

	// Advance on each beat; clear after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			if (beat.last_byte) begin
				st_q <= '0;
			end else begin
				st_q <= nxt;
			end
		end
	end

endmodule

### hdl/ehc_classify.sv
// Frame classification from the captured header state.
// Depends on ehc_pkg; purely combinational, feeds the result register.
`timescale 1ns / 1ps

module ehc_classify (
	input  ehc_pkg::frame_state_t st,
	output ehc_pkg::out_beat_t    res
);
	import ehc_pkg::*;

	logic [CNT_W-1:0] len;
	logic [CNT_W-1:0] l4;

	always_comb begin
		len = st.byte_count;
		l4  = l4_offset(st.version_ihl[3:0]);
		res = '0;
		res.frame_length = len;
		res.kind = KIND_RUNT;

		if (len >= ETH_HDR_LEN) begin
			res.dst_mac   = st.dst_mac;
			res.src_mac   = st.src_mac;
			res.ethertype = st.ethertype;

			if (st.ethertype == TYPE_ARP) begin
				res.kind = KIND_ARP;
				if (len >= ARP_MIN_LEN) begin
					res.addr_first   = st.addr_first;
					res.addr_second  = st.addr_second;
					res.arp_hw_addr  = st.hw_addr;
					res.op_or_proto  = st.op_proto;
					res.detail_valid = 1'b1;
				end
			end else if (st.ethertype == TYPE_IPV6) begin
				res.kind = KIND_IPV6;
			end else if (st.ethertype != TYPE_IPV4) begin
				res.kind = KIND_OTHER;
			end else if (len < IPV4_MIN_LEN) begin
				res.kind = KIND_V4_TRUNC;
			end else if (st.version_ihl[7:4] != IP_VERSION_4) begin
				res.kind = KIND_BAD_VER;
			end else if (st.version_ihl[3:0] < IHL_MIN) begin
				res.kind = KIND_BAD_IHL;
			end else begin
				res.kind        = KIND_IPV4;
				res.addr_first  = st.addr_first;
				res.addr_second = st.addr_second;
				res.op_or_proto = st.op_proto;
				// Report L4 detail only when it lies inside the frame
				if (st.op_proto == PROTO_ICMP) begin
					if (len >= l4 + 14'd2) begin
						res.detail_valid = 1'b1;
						res.port_first   = {8'h00, st.port_first[15:8]};
					end
				end else if (st.op_proto == PROTO_TCP || st.op_proto == PROTO_UDP) begin
					if (len >= l4 + 14'd4) begin
						res.detail_valid = 1'b1;
						res.port_first   = st.port_first;
						res.port_second  = st.port_second;
					end
				end
			end
		end
	end

endmodule

### hdl/ethernet_header_classifier.sv
// Ethernet header classifier: one result beat per frame, on its final byte.
// The final byte is first held in the input register; the result register then
// loads from it and raises result_valid. Throughput: one byte per cycle; a final
// byte waits in the input register only while a previous result is still held
// and stalled.
// Reset clears all capture state and both valids. Depends on ehc_pkg, ehc_capture, ehc_classify.
`timescale 1ns / 1ps

module ethernet_header_classifier (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               octet_valid,
	output logic               octet_stall,
	input  ehc_pkg::in_beat_t  octet,
	output logic               result_valid,
	input  logic               result_stall,
	output ehc_pkg::out_beat_t result
);
	import ehc_pkg::*;

	logic         valid_s1;
	in_beat_t     beat_s1;
	logic         consume_s1;
	frame_state_t nxt_state;
	out_beat_t    res;

	// Drain the input register unless a final byte meets a blocked result
	assign consume_s1  = valid_s1 & (~beat_s1.last_byte | ~result_valid | ~result_stall);
	assign octet_stall = valid_s1 & ~consume_s1;

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!octet_stall) begin
			valid_s1 <= octet_valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (!octet_stall) begin
			beat_s1 <= octet;
		end
	end

	ehc_capture u_capture (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (consume_s1),
		.beat   (beat_s1),
		.nxt    (nxt_state)
	);

	ehc_classify u_classify (
		.st  (nxt_state),
		.res (res)
	);

	// Result register control: load on final byte, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (consume_s1 && beat_s1.last_byte) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (consume_s1 && beat_s1.last_byte) begin
			result <= res;
		end
	end

endmodule
